@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertions on clk_i, switched off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

@@ rtl/cidst_pkg.sv @@
// ----------------------------------------------------------------------------
// cidst_pkg
// shared widths, status codes and controller/datapath interface types for
// the CAN identifier statistics table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cidst_pkg;

  localparam int unsigned ID_W    = 29;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned USED_W  = 6;

  localparam int unsigned S_TDATA_W = 104;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned M_TUSER_W = 2;

  localparam int unsigned TABLE_ENTRIES_DEF = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    STAT_UPDATED = 2'd0,
    STAT_CREATED = 2'd1,
    STAT_DROPPED = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/cidst_ctrl.sv @@
// ----------------------------------------------------------------------------
// cidst_ctrl
// sequencer: takes a request, steps the table scan, then commits the update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cidst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  cidst_pkg::sts_t sts_i,
  output cidst_pkg::cmd_t cmd_o
);
  import cidst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.hit || sts_i.done) state_d = S_WRITE;
      end
      S_WRITE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign cmd_o.load  = (state_q == S_IDLE) && req_valid_i;
  assign cmd_o.scan  = (state_q == S_SCAN) && !sts_i.hit;
  assign cmd_o.write = (state_q == S_WRITE) && sts_i.out_free;

endmodule

@@ rtl/cidst_dp.sv @@
// ----------------------------------------------------------------------------
// cidst_dp
// table memories, scan address, match compare, count update and result
// register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cidst_dp #(
  parameter int unsigned TABLE_ENTRIES = cidst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cidst_pkg::cmd_t                   cmd_i,
  output cidst_pkg::sts_t                   sts_o,
  input  logic [cidst_pkg::ID_W-1:0]        frame_id_i,
  input  logic                              is_extended_i,
  input  logic [cidst_pkg::LEN_W-1:0]       data_length_i,
  input  logic [cidst_pkg::DATA_W-1:0]      payload_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic [cidst_pkg::SLOT_W-1:0]      slot_o,
  output cidst_pkg::status_e                status_o,
  output logic [cidst_pkg::COUNT_W-1:0]     frame_count_o,
  output logic [cidst_pkg::USED_W-1:0]      entries_used_o
);
  import cidst_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KEY_W = ID_W + 1;
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(TABLE_ENTRIES);

  // table storage
  logic [KEY_W-1:0]        key_mem  [TABLE_ENTRIES];
  logic [COUNT_W-1:0]      cnt_mem  [TABLE_ENTRIES];
  logic [LEN_W+DATA_W-1:0] data_mem [TABLE_ENTRIES];

  // captured request
  logic [ID_W-1:0]   id_q;
  logic              ext_q;
  logic [LEN_W-1:0]  len_q;
  logic [DATA_W-1:0] payload_q;

  // scan
  logic [CNT_W-1:0]   addr_q;
  logic [CNT_W-1:0]   used_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [KEY_W-1:0]   key_rd_q;
  logic [COUNT_W-1:0] cnt_rd_q;

  // result
  logic               out_vld_q;
  logic [SLOT_W-1:0]  res_slot_q;
  status_e            res_status_q;
  logic [COUNT_W-1:0] res_count_q;
  logic [USED_W-1:0]  res_used_q;

  logic [KEY_W-1:0]   key_in;
  logic               hit;
  logic               room;
  logic               rd_issue;
  logic [IDX_W-1:0]   addr_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_en;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] wr_cnt;
  logic [CNT_W-1:0]   used_inc;
  logic [SLOT_W-1:0]  slot_d;
  status_e            status_d;
  logic [COUNT_W-1:0] count_d;
  logic [USED_W-1:0]  used_d;

  assign key_in   = {ext_q, id_q};
  assign hit      = rd_vld_q && (key_rd_q == key_in);
  assign room     = (used_q < DEPTH);
  assign rd_issue = cmd_i.scan && (addr_q < used_q);
  assign addr_idx = addr_q[IDX_W-1:0];
  assign cnt_inc  = (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + COUNT_W'(1);
  assign used_inc = used_q + CNT_W'(1);
  assign wr_en    = cmd_i.write && (hit || room);
  assign wr_idx   = hit ? rd_idx_q : used_q[IDX_W-1:0];
  assign wr_cnt   = hit ? cnt_inc : COUNT_W'(1);

  always_comb begin
    if (hit) begin
      slot_d   = SLOT_W'(rd_idx_q);
      status_d = STAT_UPDATED;
      count_d  = cnt_inc;
      used_d   = USED_W'(used_q);
    end else if (room) begin
      slot_d   = SLOT_W'(used_q);
      status_d = STAT_CREATED;
      count_d  = COUNT_W'(1);
      used_d   = USED_W'(used_inc);
    end else begin
      slot_d   = '0;
      status_d = STAT_DROPPED;
      count_d  = '0;
      used_d   = USED_W'(used_q);
    end
  end

  assign sts_o.hit      = hit;
  assign sts_o.done     = !rd_vld_q && (addr_q >= used_q);
  assign sts_o.out_free = !out_vld_q || res_ready_i;

  // memories: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[wr_idx]  <= wr_cnt;
      data_mem[wr_idx] <= {len_q, payload_q};
      if (!hit) begin
        key_mem[wr_idx] <= key_in;
      end
    end
    if (rd_issue) begin
      key_rd_q <= key_mem[addr_idx];
      cnt_rd_q <= cnt_mem[addr_idx];
      rd_idx_q <= addr_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q      <= frame_id_i;
      ext_q     <= is_extended_i;
      len_q     <= data_length_i;
      payload_q <= payload_i;
    end
    if (cmd_i.write) begin
      res_slot_q   <= slot_d;
      res_status_q <= status_d;
      res_count_q  <= count_d;
      res_used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rd_vld_q  <= 1'b0;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        addr_q   <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= rd_issue;
        if (rd_issue) addr_q <= addr_q + CNT_W'(1);
      end
      if (wr_en && !hit) begin
        used_q <= used_inc;
      end
      if (cmd_i.write) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign res_valid_o    = out_vld_q;
  assign slot_o         = res_slot_q;
  assign status_o       = res_status_q;
  assign frame_count_o  = res_count_q;
  assign entries_used_o = res_used_q;

  `ASSERT_CLK(a_used_bound, used_q <= DEPTH, "entry count above table depth")
  `ASSERT_CLK(a_rd_in_use, rd_vld_q |-> (CNT_W'(rd_idx_q) < used_q), "read of unused slot")
  `ASSERT_CLK(a_used_step, (used_q != $past(used_q)) |-> (used_q == $past(used_q) + CNT_W'(1)), "entry count jumped")
  `ASSERT_NEVER(a_res_no_write, $rose(out_vld_q) && !$past(cmd_i.write), "result without commit")

endmodule

@@ rtl/can_id_statistics_table.sv @@
// ----------------------------------------------------------------------------
// can_id_statistics_table
// per-identifier frame statistics: matches each received CAN frame against
// the stored identifiers, refreshes or appends an entry or drops it, and reports the slot
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (lsb first)                       | tuser
//  s_axis   | in  | frame_id, data_length, payload          | is_extended
//  m_axis   | out | slot, frame_count, entries_used         | status
//
//  a request is accepted in the idle state, then the key scan reads one slot per cycle
//  (single registered read port of the key memory) until a hit or the end of the
//  slots in use, then the update is committed once the output register is free
//  reset clears entry count, scan state and output valid; table contents are not cleared
//  a result waits in the output register while the next request is taken;
//  that request's commit waits until the result is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module can_id_statistics_table #(
  parameter int unsigned TABLE_ENTRIES = cidst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cidst_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // frame_id, data_length, payload
  input  logic [cidst_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // is_extended
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cidst_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // slot, frame_count, entries_used
  output logic [cidst_pkg::M_TUSER_W-1:0]   m_axis_tuser   // status
);
  import cidst_pkg::*;

  localparam int unsigned LEN_LO  = ID_W;
  localparam int unsigned DATA_LO = ID_W + LEN_W;
  localparam int unsigned PAD_W   = M_TDATA_W - SLOT_W - COUNT_W - USED_W;

  cmd_t               cmd;
  sts_t               sts;
  logic [SLOT_W-1:0]  slot;
  status_e            status;
  logic [COUNT_W-1:0] frame_count;
  logic [USED_W-1:0]  entries_used;

  cidst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cidst_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .frame_id_i     (s_axis_tdata[ID_W-1:0]),
    .is_extended_i  (s_axis_tuser[0]),
    .data_length_i  (s_axis_tdata[LEN_LO +: LEN_W]),
    .payload_i      (s_axis_tdata[DATA_LO +: DATA_W]),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .slot_o         (slot),
    .status_o       (status),
    .frame_count_o  (frame_count),
    .entries_used_o (entries_used)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, entries_used, frame_count, slot};
  assign m_axis_tuser = M_TUSER_W'(status);

endmodule

@@ tb/sv/can_id_statistics_table_tb.sv @@
// ----------------------------------------------------------------------------
// can_id_statistics_table_tb
// self-checking testbench: a short table of directed frames followed by
// random traffic drawn mostly from a pool of known identifiers, so that the
// table sees hits, new entries, near misses and, once full, dropped frames.
// results are checked against a behavioural copy of the table (the typed directed
// frames against their listed values), with random gaps on both stream sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module can_id_statistics_table_tb;
  import cidst_pkg::*;

  localparam int unsigned N_SLOTS        = TABLE_ENTRIES_DEF;
  localparam int unsigned N_RANDOM       = 630;
  localparam int unsigned PAUSE_AT       = 300;
  localparam int unsigned STALL_LIMIT    = 1000;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned N_DIRECTED     = 20;
  localparam logic [ID_W-1:0] ID_MAX     = '1;
  localparam logic [DATA_W-1:0] DATA_MAX = '1;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    status_e            status;
    logic [COUNT_W-1:0] frame_count;
    logic [USED_W-1:0]  entries_used;
  } frame_stat_t;

  typedef struct {
    logic [ID_W-1:0]   frame_id;
    logic              is_extended;
    logic [LEN_W-1:0]  data_length;
    logic [DATA_W-1:0] payload;
    bit                typed;
    frame_stat_t       stat;
  } can_frame_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;  // frame_id, data_length, payload
  logic [S_TUSER_W-1:0] s_axis_tuser;  // is_extended
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;  // slot, frame_count, entries_used
  logic [M_TUSER_W-1:0] m_axis_tuser;  // status

  // shadow copy of the identifier table
  logic [ID_W-1:0]    tab_id    [N_SLOTS];
  logic               tab_ext   [N_SLOTS];
  logic [LEN_W-1:0]   tab_len   [N_SLOTS];
  logic [DATA_W-1:0]  tab_data  [N_SLOTS];
  logic [COUNT_W-1:0] tab_count [N_SLOTS];
  int unsigned        tab_used;

  frame_stat_t        stat_expect_q [$];
  logic [ID_W:0]      key_pool [$];     // {is_extended, frame_id}
  can_frame_t         cur_frame;
  int unsigned        n_errors;
  int unsigned        stall_cycles;

  can_frame_t directed_frames [N_DIRECTED] = '{
    '{'0,            1'b0, 4'd0,  '0,                    1'b1,
      '{5'd0, STAT_CREATED, 32'd1, 6'd1}},
    '{'0,            1'b1, 4'd8,  DATA_MAX,              1'b1,
      '{5'd1, STAT_CREATED, 32'd1, 6'd2}},
    '{ID_MAX,        1'b1, 4'd15, DATA_MAX,              1'b1,
      '{5'd2, STAT_CREATED, 32'd1, 6'd3}},
    '{ID_MAX,        1'b0, 4'd0,  '0,                    1'b1,
      '{5'd3, STAT_CREATED, 32'd1, 6'd4}},
    '{'0,            1'b0, 4'd8,  64'h0123456789abcdef,  1'b1,
      '{5'd0, STAT_UPDATED, 32'd2, 6'd4}},
    '{ID_MAX,        1'b1, 4'd9,  '0,                    1'b1,
      '{5'd2, STAT_UPDATED, 32'd2, 6'd4}},
    '{29'h7ff,       1'b0, 4'd8,  64'hfedcba9876543210,  1'b0, '0},
    '{29'h800,       1'b0, 4'd3,  64'h00000000ffffffff,  1'b0, '0},
    '{29'h7ff,       1'b1, 4'd1,  64'hffffffff00000000,  1'b0, '0},
    '{29'h7ff,       1'b0, 4'd2,  64'h8000000000000001,  1'b0, '0},
    '{29'h800,       1'b0, 4'd4,  64'h7ffffffffffffffe,  1'b0, '0},
    '{29'h0000001,   1'b0, 4'd6,  64'h0000000000000001,  1'b0, '0},
    '{29'h1000_0000, 1'b1, 4'd7,  64'h8000000000000000,  1'b0, '0},
    '{29'h1555_5555, 1'b1, 4'd10, 64'h5555555555555555,  1'b0, '0},
    '{29'h0aaa_aaaa, 1'b0, 4'd5,  64'haaaaaaaaaaaaaaaa,  1'b0, '0},
    '{29'h1555_5555, 1'b1, 4'd11, 64'haaaaaaaaaaaaaaaa,  1'b0, '0},
    '{29'h0aaa_aaaa, 1'b1, 4'd12, 64'h5555555555555555,  1'b0, '0},
    '{'0,            1'b1, 4'd13, 64'h00ff00ff00ff00ff,  1'b0, '0},
    '{'0,            1'b0, 4'd14, 64'hff00ff00ff00ff00,  1'b0, '0},
    '{ID_MAX,        1'b0, 4'd8,  64'h0f0f0f0f0f0f0f0f,  1'b0, '0}
  };

  can_id_statistics_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic frame_stat_t lookup_and_update(input can_frame_t f);
    frame_stat_t res;
    int          hit;
    hit = -1;
    for (int i = 0; i < tab_used; i++) begin
      if (hit < 0 && tab_id[i] == f.frame_id && tab_ext[i] == f.is_extended) hit = i;
    end
    res = '{'0, STAT_DROPPED, '0, '0};
    if (hit >= 0) begin
      tab_len[hit]  = f.data_length;
      tab_data[hit] = f.payload;
      if (tab_count[hit] != COUNT_MAX) tab_count[hit] = tab_count[hit] + 1'b1;
      res.slot        = SLOT_W'(hit);
      res.status      = STAT_UPDATED;
      res.frame_count = tab_count[hit];
    end else if (tab_used < N_SLOTS) begin
      tab_id[tab_used]    = f.frame_id;
      tab_ext[tab_used]   = f.is_extended;
      tab_len[tab_used]   = f.data_length;
      tab_data[tab_used]  = f.payload;
      tab_count[tab_used] = COUNT_W'(1);
      res.slot            = SLOT_W'(tab_used);
      res.status          = STAT_CREATED;
      res.frame_count     = COUNT_W'(1);
      tab_used            = tab_used + 1;
    end
    res.entries_used = USED_W'(tab_used);
    return res;
  endfunction

  // mostly known identifiers, some near misses, some fresh ones
  function automatic can_frame_t random_frame();
    can_frame_t    f;
    logic [ID_W:0] key;
    int unsigned   r;
    r = $urandom_range(0, 99);
    if (key_pool.size() == 0 || r < 25) begin
      if ($urandom_range(0, 1)) key = {1'b0, ID_W'($urandom_range(0, 2047))};
      else key = {1'(($urandom_range(0, 1))), ID_W'($urandom)};
      key_pool.push_back(key);
    end else begin
      if ($urandom_range(0, 1) && key_pool.size() > 40)
        key = key_pool[$urandom_range(0, 39)];
      else
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (r < 37) begin
        if ($urandom_range(0, 1)) key[ID_W] = ~key[ID_W];
        else key[$urandom_range(0, ID_W - 1)] ^= 1'b1;
        key_pool.push_back(key);
      end
    end
    f.frame_id    = key[ID_W-1:0];
    f.is_extended = key[ID_W];
    r = $urandom_range(0, 99);
    f.data_length = (r < 80) ? LEN_W'($urandom_range(0, 8)) : LEN_W'($urandom_range(9, 15));
    r = $urandom_range(0, 99);
    if (r < 5) f.payload = '0;
    else if (r < 10) f.payload = DATA_MAX;
    else f.payload = {$urandom, $urandom};
    f.typed = 1'b0;
    f.stat  = '0;
    return f;
  endfunction

  task automatic send_frame(input can_frame_t f);
    int unsigned gap;
    cur_frame     = f;
    s_axis_tdata  = {{(S_TDATA_W - ID_W - LEN_W - DATA_W){1'b0}},
                     f.payload, f.data_length, f.frame_id};
    s_axis_tuser  = f.is_extended;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (stat_expect_q.size() != 0) @(negedge clk_i);
  endtask

  // result checking, shadow table update and watchdog
  always @(posedge clk_i) begin
    frame_stat_t got;
    frame_stat_t want;
    frame_stat_t pred;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        moved            = 1'b1;
        got.slot         = m_axis_tdata[SLOT_W-1:0];
        got.frame_count  = m_axis_tdata[SLOT_W +: COUNT_W];
        got.entries_used = m_axis_tdata[SLOT_W + COUNT_W +: USED_W];
        got.status       = status_e'(m_axis_tuser);
        if (stat_expect_q.size() == 0) begin
          $error("unexpected result: slot %0d status %0d", got.slot, got.status);
          n_errors++;
        end else begin
          want = stat_expect_q.pop_front();
          if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            n_errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_errors++;
          end
          if (got.frame_count !== want.frame_count) begin
            $error("frame_count: expected %0d, got %0d", want.frame_count, got.frame_count);
            n_errors++;
          end
          if (got.entries_used !== want.entries_used) begin
            $error("entries_used: expected %0d, got %0d", want.entries_used,
                   got.entries_used);
            n_errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        pred  = lookup_and_update(cur_frame);
        stat_expect_q.push_back(cur_frame.typed ? cur_frame.stat : pred);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int unsigned hold;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      m_axis_tready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
      hold = idle_gap();
      if (hold > 0) begin
        m_axis_tready = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cur_frame     = '{'0, 1'b0, '0, '0, 1'b0, '0};
    tab_used      = 0;
    n_errors      = 0;
    stall_cycles  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_frames[i]) begin
      key_pool.push_back({directed_frames[i].is_extended, directed_frames[i].frame_id});
      send_frame(directed_frames[i]);
    end
    drain_results();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == PAUSE_AT) drain_results();
      send_frame(random_frame());
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
